@@ hw/rtl/mta_pkg.sv @@
// ----------------------------------------------------------------------------
// mta_pkg
// Shared types, constants and helpers for the mesh tangent accumulator.
// ----------------------------------------------------------------------------
package mta_pkg;

	// Vertex slots and field widths
	localparam int MAX_VERTICES = 256;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int IDX_W        = 8;
	localparam int CRD_W        = 32;
	localparam int ACC_W        = 48;
	localparam int TAN_W        = 16;
	localparam int VTX_W        = 5 * CRD_W;
	localparam int ACC_WORD_W   = 3 * ACC_W;

	// Stream payload layout
	localparam int IN_DATA_W    = 192;
	localparam int IN_USER_W    = 2;
	localparam int OUT_DATA_W   = 56;
	localparam int VTX_LO       = IDX_W;
	localparam int CA_LO        = IDX_W + VTX_W;
	localparam int CB_LO        = CA_LO + IDX_W;
	localparam int CC_LO        = CB_LO + IDX_W;

	// Divider step counts
	localparam int TDIV_STEPS   = 48;
	localparam int QDIV_STEPS   = 16;
	localparam int DCNT_W       = $clog2(TDIV_STEPS + 1);

	// Unit length in Q1.14
	localparam logic [TAN_W-1:0] UNIT_Q14 = 16'd16384;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_TRI   = 2'd1,
		CMD_READ  = 2'd2,
		CMD_CLEAR = 2'd3
	} command_t;

	// One vertex word, position x in the lowest bits
	typedef struct packed {
		logic [CRD_W-1:0]      v;
		logic [CRD_W-1:0]      u;
		logic [2:0][CRD_W-1:0] pos;
	} vtx_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_VFETCH,
		OP_DIFF,
		OP_DET0,
		OP_DET1,
		OP_DET2,
		OP_NUM0,
		OP_NUM1,
		OP_NUM2,
		OP_TDIV_LD,
		OP_DIV_STEP,
		OP_TDIV_END,
		OP_ACC_RD,
		OP_ACC_WR,
		OP_ROT,
		OP_RD_ACC,
		OP_RD_CAP,
		OP_NORM,
		OP_SQ_MUL,
		OP_SQRT_LD,
		OP_SQRT_STEP,
		OP_QDIV_LD,
		OP_QDIV_END
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_VRD_A,
		ST_VRD_B,
		ST_VRD_C,
		ST_VWAIT,
		ST_DIFF,
		ST_DET0,
		ST_DET1,
		ST_DET2,
		ST_CHK,
		ST_NUM0,
		ST_NUM1,
		ST_NUM2,
		ST_TDIV_LD,
		ST_TDIV_RUN,
		ST_TDIV_END,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_ROT,
		ST_RD_ACC,
		ST_RD_CAP,
		ST_NORM,
		ST_SQ0,
		ST_SQ1,
		ST_SQ2,
		ST_SQRT_LD,
		ST_SQRT_RUN,
		ST_QDIV_LD,
		ST_QDIV_RUN,
		ST_QDIV_END,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       take;
		op_t        op;
		logic [1:0] sel;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic in_range;
		logic det_zero;
		logic div_done;
		logic big_zero;
		logic norm_done;
		logic sqrt_done;
		logic out_free;
	} dp_sts_t;

	// Slot index inside the store
	function automatic logic idx_ok(input logic [IDX_W-1:0] i);
		return (int'(i) < MAX_VERTICES);
	endfunction

	// Difference saturated to 32 bits
	function automatic logic signed [CRD_W-1:0] sat_diff(
		input logic signed [CRD_W-1:0] a,
		input logic signed [CRD_W-1:0] b
	);
		logic signed [CRD_W:0] d;
		d = {a[CRD_W-1], a} - {b[CRD_W-1], b};
		if (d[CRD_W] != d[CRD_W-1]) begin
			return d[CRD_W] ? {1'b1, {(CRD_W-1){1'b0}}} : {1'b0, {(CRD_W-1){1'b1}}};
		end
		return d[CRD_W-1:0];
	endfunction

	// Magnitude of a 64-bit signed value
	function automatic logic [63:0] mag64(input logic signed [63:0] x);
		return x[63] ? 64'(-x) : 64'(x);
	endfunction

endpackage

@@ hw/rtl/mta_ram.sv @@
// ----------------------------------------------------------------------------
// mta_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mta_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/mta_ctrl.sv @@
// ----------------------------------------------------------------------------
// mta_ctrl
// Sequencer: steps the datapath through load, triangle, read and clear.
// ----------------------------------------------------------------------------
module mta_ctrl import mta_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	input  command_t in_cmd,
	output logic     s_tready,
	output dp_cmd_t  cmd,
	input  dp_sts_t  sts
);

	state_t     state_q, state_d;
	logic [1:0] k_q, k_d;
	logic [1:0] corner_q, corner_d;

	// State and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			k_q      <= 2'd0;
			corner_q <= 2'd0;
		end else begin
			state_q  <= state_d;
			k_q      <= k_d;
			corner_q <= corner_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d      = state_q;
		k_d          = k_q;
		corner_d     = corner_q;
		s_tready     = 1'b0;
		cmd.take     = 1'b0;
		cmd.op       = OP_NONE;
		cmd.sel      = k_q;
		cmd.out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take = 1'b1;
					unique case (in_cmd)
						CMD_TRI:  state_d = sts.in_range ? ST_VRD_A : ST_IDLE;
						CMD_READ: state_d = sts.in_range ? ST_RD_ACC : ST_OUT;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			// Fetch the three corners
			ST_VRD_A: begin
				cmd.op  = OP_VFETCH;
				cmd.sel = 2'd0;
				state_d = ST_VRD_B;
			end
			ST_VRD_B: begin
				cmd.op  = OP_VFETCH;
				cmd.sel = 2'd1;
				state_d = ST_VRD_C;
			end
			ST_VRD_C: begin
				cmd.op  = OP_VFETCH;
				cmd.sel = 2'd2;
				state_d = ST_VWAIT;
			end
			ST_VWAIT: begin
				corner_d = 2'd0;
				state_d  = ST_DIFF;
			end
			// Per-corner determinant
			ST_DIFF: begin
				cmd.op  = OP_DIFF;
				state_d = ST_DET0;
			end
			ST_DET0: begin
				cmd.op  = OP_DET0;
				state_d = ST_DET1;
			end
			ST_DET1: begin
				cmd.op  = OP_DET1;
				state_d = ST_DET2;
			end
			ST_DET2: begin
				cmd.op  = OP_DET2;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				k_d     = 2'd0;
				state_d = sts.det_zero ? ST_ROT : ST_NUM0;
			end
			// Per-axis numerator and scaled divide
			ST_NUM0: begin
				cmd.op  = OP_NUM0;
				state_d = ST_NUM1;
			end
			ST_NUM1: begin
				cmd.op  = OP_NUM1;
				state_d = ST_NUM2;
			end
			ST_NUM2: begin
				cmd.op  = OP_NUM2;
				state_d = ST_TDIV_LD;
			end
			ST_TDIV_LD: begin
				cmd.op  = OP_TDIV_LD;
				state_d = ST_TDIV_RUN;
			end
			ST_TDIV_RUN: begin
				if (sts.div_done) begin
					state_d = ST_TDIV_END;
				end else begin
					cmd.op = OP_DIV_STEP;
				end
			end
			ST_TDIV_END: begin
				cmd.op = OP_TDIV_END;
				if (k_q == 2'd2) begin
					state_d = ST_ACC_RD;
				end else begin
					k_d     = k_q + 2'd1;
					state_d = ST_NUM0;
				end
			end
			// Read-modify-write of the corner's accumulator
			ST_ACC_RD: begin
				cmd.op  = OP_ACC_RD;
				state_d = ST_ACC_WR;
			end
			ST_ACC_WR: begin
				cmd.op  = OP_ACC_WR;
				state_d = ST_ROT;
			end
			ST_ROT: begin
				cmd.op = OP_ROT;
				if (corner_q == 2'd2) begin
					state_d = ST_IDLE;
				end else begin
					corner_d = corner_q + 2'd1;
					state_d  = ST_DIFF;
				end
			end
			// Read: fetch and normalise
			ST_RD_ACC: begin
				cmd.op  = OP_RD_ACC;
				state_d = ST_RD_CAP;
			end
			ST_RD_CAP: begin
				cmd.op  = OP_RD_CAP;
				state_d = ST_NORM;
			end
			ST_NORM: begin
				priority if (sts.big_zero) begin
					state_d = ST_OUT;
				end else if (sts.norm_done) begin
					state_d = ST_SQ0;
				end else begin
					cmd.op = OP_NORM;
				end
			end
			// Sum of squares
			ST_SQ0: begin
				cmd.op  = OP_SQ_MUL;
				cmd.sel = 2'd0;
				state_d = ST_SQ1;
			end
			ST_SQ1: begin
				cmd.op  = OP_SQ_MUL;
				cmd.sel = 2'd1;
				state_d = ST_SQ2;
			end
			ST_SQ2: begin
				cmd.op  = OP_SQ_MUL;
				cmd.sel = 2'd2;
				state_d = ST_SQRT_LD;
			end
			ST_SQRT_LD: begin
				cmd.op  = OP_SQRT_LD;
				state_d = ST_SQRT_RUN;
			end
			ST_SQRT_RUN: begin
				k_d = 2'd0;
				if (sts.sqrt_done) begin
					state_d = ST_QDIV_LD;
				end else begin
					cmd.op = OP_SQRT_STEP;
				end
			end
			// Per-axis divide by the length
			ST_QDIV_LD: begin
				cmd.op  = OP_QDIV_LD;
				state_d = ST_QDIV_RUN;
			end
			ST_QDIV_RUN: begin
				if (sts.div_done) begin
					state_d = ST_QDIV_END;
				end else begin
					cmd.op = OP_DIV_STEP;
				end
			end
			ST_QDIV_END: begin
				cmd.op = OP_QDIV_END;
				if (k_q == 2'd2) begin
					state_d = ST_OUT;
				end else begin
					k_d     = k_q + 2'd1;
					state_d = ST_QDIV_LD;
				end
			end
			// Hand the result to the output register
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/mta_datapath.sv @@
// ----------------------------------------------------------------------------
// mta_datapath
// Vertex and accumulator stores, shared multiplier, bit-serial divider,
// square root and output register.
// ----------------------------------------------------------------------------
module mta_datapath import mta_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  command_t              in_cmd,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tuser
);

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// Input fields
	logic [IDX_W-1:0] in_idx, in_ca, in_cb, in_cc;

	// Captured item and corner data
	logic [IDX_W-1:0]              idx_q;
	logic [2:0][IDX_W-1:0]         cidx_q;
	vtx_t                          vtx_q [3];
	logic                          vpend_s1;
	logic [1:0]                    vslot_s1;
	logic signed [CRD_W-1:0]       du1_q, dv1_q, du2_q, dv2_q;
	logic signed [CRD_W-1:0]       e1_q [3];
	logic signed [CRD_W-1:0]       e2_q [3];

	// Multiplier and products
	logic signed [CRD_W-1:0]       mul_a, mul_b;
	logic signed [63:0]            prod_q, tmp_q, det_q, num_q;
	logic signed [ACC_W-1:0]       contrib_q [3];

	// Divider
	logic [63:0]                   dr_q, dvs_q;
	logic [47:0]                   dd_q, dq_q;
	logic [DCNT_W-1:0]             dcnt_q;
	logic                          dsat_q, dneg_q;
	logic [64:0]                   d_rs, d_diff;
	logic                          d_ge;
	logic [63:0]                   t_an, t_ad;
	logic [46:0]                   q_dvd;

	// Read path
	logic [2:0]                    vneg_q;
	logic [ACC_W-1:0]              m_q [3];
	logic [ACC_W-1:0]              big_q;
	logic [63:0]                   sum_q;
	logic [63:0]                   sn_q, sres_q, sbit_q, s_t;
	logic signed [TAN_W-1:0]       comp_q [3];
	logic                          zero_q;

	// Stores
	logic [MAX_VERTICES-1:0]       valid_q;
	logic                          vld_rd_s1;
	logic                          vram_we, vram_re, aram_re, aram_we;
	logic [VIDX_W-1:0]             vram_raddr, aram_raddr, aram_waddr;
	logic [VTX_W-1:0]              vram_rdata;
	logic [2:0][ACC_W-1:0]         aram_rdata, acc_new;

	// Capture combinational helpers
	logic signed [ACC_W-1:0]       raw [3];
	logic [ACC_W-1:0]              rmag [3];
	logic [ACC_W-1:0]              rmax;
	logic [TAN_W-1:0]              qclamp;
	logic signed [ACC_W-1:0]       tcontrib;

	// Output register
	logic                          out_vld_q;
	logic signed [TAN_W-1:0]       out_t_q [3];
	logic [IDX_W-1:0]              out_idx_q;
	logic                          out_zero_q;

	assign in_idx = s_tdata[0 +: IDX_W];
	assign in_ca  = s_tdata[CA_LO +: IDX_W];
	assign in_cb  = s_tdata[CB_LO +: IDX_W];
	assign in_cc  = s_tdata[CC_LO +: IDX_W];

	// Store ports
	assign vram_we    = cmd.take && (in_cmd == CMD_LOAD) && idx_ok(in_idx);
	assign vram_re    = (cmd.op == OP_VFETCH);
	assign vram_raddr = cidx_q[cmd.sel][VIDX_W-1:0];
	assign aram_re    = (cmd.op == OP_ACC_RD) || (cmd.op == OP_RD_ACC);
	assign aram_raddr = (cmd.op == OP_RD_ACC) ? idx_q[VIDX_W-1:0] : cidx_q[0][VIDX_W-1:0];
	assign aram_we    = (cmd.op == OP_ACC_WR);
	assign aram_waddr = cidx_q[0][VIDX_W-1:0];

	mta_ram #(
		.WIDTH (VTX_W),
		.DEPTH (MAX_VERTICES)
	) u_vtx_ram (
		.clk   (clk),
		.we    (vram_we),
		.waddr (in_idx[VIDX_W-1:0]),
		.wdata (s_tdata[VTX_LO +: VTX_W]),
		.re    (vram_re),
		.raddr (vram_raddr),
		.rdata (vram_rdata)
	);

	mta_ram #(
		.WIDTH (ACC_WORD_W),
		.DEPTH (MAX_VERTICES)
	) u_acc_ram (
		.clk   (clk),
		.we    (aram_we),
		.waddr (aram_waddr),
		.wdata (acc_new),
		.re    (aram_re),
		.raddr (aram_raddr),
		.rdata (aram_rdata)
	);

	// Accumulator add with saturation; an entry not yet written reads as zero
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [ACC_W-1:0] old;
			logic signed [ACC_W:0]   s;
			old = vld_rd_s1 ? aram_rdata[k] : '0;
			s   = {old[ACC_W-1], old} + {contrib_q[k][ACC_W-1], contrib_q[k]};
			if (s[ACC_W] != s[ACC_W-1]) begin
				acc_new[k] = s[ACC_W] ? ACC_MIN : ACC_MAX;
			end else begin
				acc_new[k] = s[ACC_W-1:0];
			end
		end
	end

	// Multiplier operand select
	always_comb begin
		unique case (cmd.op)
			OP_DET1: begin
				mul_a = dv1_q;
				mul_b = du2_q;
			end
			OP_NUM0: begin
				mul_a = dv2_q;
				mul_b = e1_q[cmd.sel];
			end
			OP_NUM1: begin
				mul_a = dv1_q;
				mul_b = e2_q[cmd.sel];
			end
			OP_SQ_MUL: begin
				mul_a = m_q[cmd.sel][CRD_W-1:0];
				mul_b = m_q[cmd.sel][CRD_W-1:0];
			end
			default: begin
				mul_a = du1_q;
				mul_b = dv2_q;
			end
		endcase
	end

	// Divider step, square root step and load values
	assign d_rs   = {dr_q, dd_q[47]};
	assign d_diff = d_rs - {1'b0, dvs_q};
	assign d_ge   = (d_rs >= {1'b0, dvs_q});
	assign t_an   = mag64(num_q);
	assign t_ad   = mag64(det_q);
	assign q_dvd  = {1'b0, m_q[cmd.sel][30:0], 15'b0} + {15'b0, sres_q[31:0]};
	assign s_t    = sres_q + sbit_q;

	// Accumulator capture: sign, magnitude and largest magnitude
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			raw[k]  = vld_rd_s1 ? aram_rdata[k] : '0;
			rmag[k] = raw[k][ACC_W-1] ? ACC_W'(-raw[k]) : ACC_W'(raw[k]);
		end
		rmax = rmag[0];
		if (rmag[1] > rmax) begin
			rmax = rmag[1];
		end
		if (rmag[2] > rmax) begin
			rmax = rmag[2];
		end
	end

	// Clamp the unit-vector component, form the triangle contribution
	always_comb begin
		qclamp = (dq_q[TAN_W-1:0] > UNIT_Q14) ? UNIT_Q14 : dq_q[TAN_W-1:0];
		if (dsat_q || dq_q[47]) begin
			tcontrib = dneg_q ? ACC_MIN : ACC_MAX;
		end else begin
			tcontrib = dneg_q ? -$signed(dq_q) : $signed(dq_q);
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vpend_s1 <= 1'b0;
		end else begin
			vpend_s1 <= (cmd.op == OP_VFETCH);
			if (cmd.take && (in_cmd == CMD_CLEAR)) begin
				valid_q <= '0;
			end else if (aram_we) begin
				valid_q[aram_waddr] <= 1'b1;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		vslot_s1 <= cmd.sel;
		if (aram_re) begin
			vld_rd_s1 <= valid_q[aram_raddr];
		end
		if (vpend_s1) begin
			vtx_q[vslot_s1] <= vram_rdata;
		end
		if (cmd.take) begin
			idx_q  <= in_idx;
			cidx_q <= {in_cc, in_cb, in_ca};
			zero_q <= 1'b1;
			for (int k = 0; k < 3; k++) begin
				comp_q[k] <= '0;
			end
		end
		unique case (cmd.op)
			OP_DIFF: begin
				du1_q <= sat_diff(vtx_q[1].u, vtx_q[0].u);
				dv1_q <= sat_diff(vtx_q[1].v, vtx_q[0].v);
				du2_q <= sat_diff(vtx_q[2].u, vtx_q[0].u);
				dv2_q <= sat_diff(vtx_q[2].v, vtx_q[0].v);
				for (int k = 0; k < 3; k++) begin
					e1_q[k] <= sat_diff(vtx_q[1].pos[k], vtx_q[0].pos[k]);
					e2_q[k] <= sat_diff(vtx_q[2].pos[k], vtx_q[0].pos[k]);
				end
			end
			OP_DET0, OP_NUM0: begin
				prod_q <= mul_a * mul_b;
			end
			OP_DET1, OP_NUM1: begin
				prod_q <= mul_a * mul_b;
				tmp_q  <= prod_q;
			end
			OP_DET2: begin
				det_q <= tmp_q - prod_q;
			end
			OP_NUM2: begin
				num_q <= tmp_q - prod_q;
			end
			OP_TDIV_LD: begin
				dr_q   <= {32'b0, t_an[63:32]};
				dd_q   <= {t_an[31:0], 16'b0};
				dvs_q  <= t_ad;
				dsat_q <= ({32'b0, t_an[63:32]} >= t_ad);
				dneg_q <= num_q[63] ^ det_q[63];
				dq_q   <= '0;
				dcnt_q <= DCNT_W'(TDIV_STEPS);
			end
			OP_DIV_STEP: begin
				dr_q   <= d_ge ? d_diff[63:0] : d_rs[63:0];
				dd_q   <= {dd_q[46:0], 1'b0};
				dq_q   <= {dq_q[46:0], d_ge};
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end
			OP_TDIV_END: begin
				contrib_q[cmd.sel] <= tcontrib;
			end
			OP_ROT: begin
				cidx_q   <= {cidx_q[0], cidx_q[2], cidx_q[1]};
				vtx_q[0] <= vtx_q[1];
				vtx_q[1] <= vtx_q[2];
				vtx_q[2] <= vtx_q[0];
			end
			OP_RD_CAP: begin
				for (int k = 0; k < 3; k++) begin
					vneg_q[k] <= raw[k][ACC_W-1];
					m_q[k]    <= rmag[k];
					comp_q[k] <= '0;
				end
				big_q  <= rmax;
				zero_q <= (rmax == '0);
			end
			OP_NORM: begin
				// Shift all magnitudes together until the largest sits at bit 30
				if (big_q[ACC_W-1:31] != '0) begin
					big_q <= big_q >> 1;
					for (int k = 0; k < 3; k++) begin
						m_q[k] <= m_q[k] >> 1;
					end
				end else begin
					big_q <= big_q << 1;
					for (int k = 0; k < 3; k++) begin
						m_q[k] <= m_q[k] << 1;
					end
				end
			end
			OP_SQ_MUL: begin
				prod_q <= mul_a * mul_b;
				sum_q  <= (cmd.sel == 2'd0) ? 64'd0 : sum_q + prod_q;
			end
			OP_SQRT_LD: begin
				sn_q   <= sum_q + prod_q;
				sres_q <= '0;
				sbit_q <= 64'd1 << 62;
			end
			OP_SQRT_STEP: begin
				if (sn_q >= s_t) begin
					sn_q   <= sn_q - s_t;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end
			OP_QDIV_LD: begin
				dr_q   <= {33'b0, q_dvd[46:16]};
				dd_q   <= {q_dvd[15:0], 32'b0};
				dvs_q  <= {31'b0, sres_q[31:0], 1'b0};
				dsat_q <= 1'b0;
				dneg_q <= vneg_q[cmd.sel];
				dq_q   <= '0;
				dcnt_q <= DCNT_W'(QDIV_STEPS);
			end
			OP_QDIV_END: begin
				comp_q[cmd.sel] <= dneg_q ? -$signed(qclamp) : $signed(qclamp);
			end
			default: begin
			end
		endcase
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			for (int k = 0; k < 3; k++) begin
				out_t_q[k] <= comp_q[k];
			end
			out_idx_q  <= idx_q;
			out_zero_q <= zero_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_idx_q, out_t_q[2], out_t_q[1], out_t_q[0]};
	assign m_tuser  = out_zero_q;

	// Status to the sequencer
	always_comb begin
		unique case (in_cmd)
			CMD_READ: sts.in_range = idx_ok(in_idx);
			CMD_TRI:  sts.in_range = idx_ok(in_ca) && idx_ok(in_cb) && idx_ok(in_cc);
			default:  sts.in_range = 1'b1;
		endcase
		sts.det_zero  = (det_q == '0);
		sts.div_done  = (dcnt_q == '0);
		sts.big_zero  = (big_q == '0);
		sts.norm_done = (big_q[ACC_W-1:31] == '0) && big_q[30];
		sts.sqrt_done = (sbit_q == '0);
		sts.out_free  = !out_vld_q || m_tready;
	end

endmodule

@@ hw/rtl/mesh_tangent_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// mesh_tangent_accumulator_unit
// Per-vertex tangent accumulation over triangles, with normalised read-back.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_tvalid/s_tready; s_tuser carries the command
//   (load vertex, accumulate triangle, read tangent, clear accumulators).
//   Only a read produces a result item on m_tvalid/m_tready.
//   Load and clear complete as the item is accepted. A triangle fetches its
//   corners, then runs three corners, each a determinant and a zero check
//   plus, when it is nonzero, three multiply-and-divide passes through one
//   bit-serial 48-step divider and an accumulator update.
//   A read of a nonzero vector runs one normalising shift per cycle (up to
//   30), a 32-step square root, then three 16-step divides.
//   A read of a zero vector skips these steps.
//   Work is one item at a time; a new item is taken once the previous one
//   has finished. A result waits in the output register while the receiver
//   stalls, and the next item can already be accepted meanwhile.
//   Reset clears all accumulators at once through per-slot valid bits;
//   vertex data is undefined until loaded.
// ----------------------------------------------------------------------------
module mesh_tangent_accumulator_unit import mta_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v, corner_a, corner_b, corner_c
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// command
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// tangent_x, tangent_y, tangent_z, read_index
	output logic [OUT_DATA_W-1:0] m_tdata,
	// zero_tangent
	output logic                  m_tuser
);

	command_t in_cmd;
	dp_cmd_t  cmd;
	dp_sts_t  sts;

	assign in_cmd = command_t'(s_tuser);

	mta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.in_cmd   (in_cmd),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	mta_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.in_cmd   (in_cmd),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

@@ hw/rtl/mta_checker.sv @@
// ----------------------------------------------------------------------------
// mta_checker
// Port-level checks for the mesh tangent accumulator.
// ----------------------------------------------------------------------------
module mta_checker import mta_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_USER_W-1:0]  s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tuser
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// Zero flag comes with zero components
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[47:0] == 48'd0)
		else $error("zero tangent with nonzero components");

	// Components stay within the unit range
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
			($signed(m_tdata[15:0]) <= 16'sd16384) && ($signed(m_tdata[15:0]) >= -16'sd16384) &&
			($signed(m_tdata[31:16]) <= 16'sd16384) && ($signed(m_tdata[31:16]) >= -16'sd16384) &&
			($signed(m_tdata[47:32]) <= 16'sd16384) && ($signed(m_tdata[47:32]) >= -16'sd16384))
		else $error("tangent component out of range");

	// A read item keeps the input closed while it is worked on
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == CMD_READ) |=> !s_tready)
		else $error("input open right after a read item");

endmodule

bind mesh_tangent_accumulator_unit mta_checker u_mta_checker (.*);
